[sv/assert_macros.svh]
// Assertion helpers used by ptx_out.
// Each macro takes a label, clock, active-low reset, a condition, a consequence and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define PTX_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequence must hold in the cycle after the condition.
`define PTX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ptx_pkg.sv]
package ptx_pkg;

	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam int FIELD_W   = 16;
	localparam int PHASE_W   = 16;
	localparam int TEXTURE_W = 19;
	localparam int ANGLE_W   = 33;
	localparam int ATAN_LEN  = 24;

	localparam logic signed [PHASE_W-1:0] HALF_PI_Q13 = 16'sd12868;
	localparam logic signed [PHASE_W-1:0] PI_Q13      = 16'sd25736;
	localparam logic signed [18:0]        SQRT3_Q16   = 19'sd113512;

	localparam int FRAC_SHIFT  = 16;
	localparam int ROOT_PAD    = 20;
	localparam int SUM_SHIFT   = 10;
	localparam int ROUND_BIAS  = 384;
	localparam int ROUND_SHIFT = 8;
	localparam int ANGLE_SHIFT = 17;
	localparam logic signed [ANGLE_W:0] ANGLE_ROUND = 34'sd65536;

	typedef struct packed {
		logic [FIELD_W-1:0] sample_one;
		logic [FIELD_W-1:0] sample_two;
		logic [FIELD_W-1:0] sample_three;
	} ptx_pixel_t;

	typedef struct packed {
		logic signed [PHASE_W-1:0] phase;
		logic [TEXTURE_W-1:0]      texture;
	} ptx_result_t;

	// Phase decided up front for degenerate inputs; travels beside the CORDIC.
	typedef struct packed {
		logic                      special;
		logic signed [PHASE_W-1:0] value;
	} ptx_ph_tag_t;

	// atan(2^-i) in Q2.30.
	function automatic logic signed [ANGLE_W-1:0] ptx_atan(input int idx);
		logic signed [ANGLE_W-1:0] r;
		case (idx)
			0:  r = 33'sd843314857;
			1:  r = 33'sd497837829;
			2:  r = 33'sd263043837;
			3:  r = 33'sd133525159;
			4:  r = 33'sd67021687;
			5:  r = 33'sd33543516;
			6:  r = 33'sd16775851;
			7:  r = 33'sd8388437;
			8:  r = 33'sd4194283;
			9:  r = 33'sd2097149;
			10: r = 33'sd1048576;
			11: r = 33'sd524288;
			12: r = 33'sd262144;
			13: r = 33'sd131072;
			14: r = 33'sd65536;
			15: r = 33'sd32768;
			16: r = 33'sd16384;
			17: r = 33'sd8192;
			18: r = 33'sd4096;
			19: r = 33'sd2048;
			20: r = 33'sd1024;
			21: r = 33'sd512;
			22: r = 33'sd256;
			23: r = 33'sd128;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[sv/ptx_front.sv]
module ptx_front import ptx_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  ptx_pixel_t                    pix,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS+19:0] cx,
	output logic signed [SAMPLE_BITS+19:0] cy,
	output logic [2*SAMPLE_BITS+23:0]     rad,
	output logic [SAMPLE_BITS+1:0]        sum,
	output ptx_ph_tag_t                   tag
);

	localparam int SB     = SAMPLE_BITS;
	localparam int AW     = SB + 1;
	localparam int XW     = SB + 2;
	localparam int CW     = SB + 20;
	localparam int XSQ_W  = 2 * AW;
	localparam int DSQ_W  = 2 * SB;
	localparam int QW     = 2 * SB + 3;
	localparam int RAD_W  = 2 * SB + 24;

	logic [SB-1:0]        a, b, c;
	logic signed [SB:0]   d;
	logic signed [XW-1:0] x;
	logic [XW-1:0]        sum_c;
	logic [AW-1:0]        xabs;
	logic [SB-1:0]        dabs;
	logic signed [SB:0]   dn;
	ptx_ph_tag_t          tag_c;

	logic                 v_s1, v_s2, v_s3;
	logic [AW-1:0]        xabs_s1;
	logic [SB-1:0]        dabs_s1;
	logic signed [SB:0]   dn_s1;
	logic [XW-1:0]        sum_s1, sum_s2, sum_s3;
	ptx_ph_tag_t          tag_s1, tag_s2, tag_s3;
	logic signed [CW-1:0] cy_mul;
	logic signed [CW-1:0] cx_s2, cy_s2, cx_s3, cy_s3;
	logic [XSQ_W-1:0]     xsq_s2;
	logic [DSQ_W-1:0]     dsq_s2;
	logic [QW-1:0]        quad;
	logic [RAD_W-1:0]     rad_s3;

	assign a = pix.sample_one[SB-1:0];
	assign b = pix.sample_two[SB-1:0];
	assign c = pix.sample_three[SB-1:0];

	assign d     = $signed({1'b0, a}) - $signed({1'b0, c});
	assign x     = $signed({1'b0, b, 1'b0}) - $signed({2'b00, a}) - $signed({2'b00, c});
	assign sum_c = {2'b00, a} + {2'b00, b} + {2'b00, c};
	assign xabs  = x[XW-1] ? AW'(-x) : AW'(x);
	assign dabs  = d[SB] ? SB'(-d) : SB'(d);
	// The CORDIC works in the right half plane, so a negative x flips both terms.
	assign dn    = x[XW-1] ? -d : d;

	always_comb begin
		tag_c = '0;
		if (a == c && b == c) begin
			tag_c.special = 1'b1;
			tag_c.value   = PI_Q13;
		end else if (x == '0) begin
			tag_c.special = 1'b1;
			tag_c.value   = (d > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
		end else if (d == '0) begin
			tag_c.special = 1'b1;
			tag_c.value   = '0;
		end
	end

	assign cy_mul = CW'(dn_s1) * CW'(SQRT3_Q16);
	assign quad   = QW'(xsq_s2) + QW'(dsq_s2) + (QW'(dsq_s2) << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xabs_s1 <= xabs;
			dabs_s1 <= dabs;
			dn_s1   <= dn;
			sum_s1  <= sum_c;
			tag_s1  <= tag_c;

			cx_s2   <= $signed(CW'(xabs_s1) << FRAC_SHIFT);
			cy_s2   <= cy_mul;
			xsq_s2  <= XSQ_W'(xabs_s1) * XSQ_W'(xabs_s1);
			dsq_s2  <= DSQ_W'(dabs_s1) * DSQ_W'(dabs_s1);
			sum_s2  <= sum_s1;
			tag_s2  <= tag_s1;

			cx_s3   <= cx_s2;
			cy_s3   <= cy_s2;
			rad_s3  <= RAD_W'(quad) << ROOT_PAD;
			sum_s3  <= sum_s2;
			tag_s3  <= tag_s2;
		end
	end

	assign out_valid = v_s3;
	assign cx        = cx_s3;
	assign cy        = cy_s3;
	assign rad       = rad_s3;
	assign sum       = sum_s3;
	assign tag       = tag_s3;

endmodule

[sv/ptx_cell.sv]
module ptx_cell import ptx_pkg::*; #(
	parameter int IDX           = 0,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic                           in_valid,
	input  logic signed [SAMPLE_BITS+19:0] in_cx,
	input  logic signed [SAMPLE_BITS+19:0] in_cy,
	input  logic signed [ANGLE_W-1:0]      in_z,
	input  logic [2*SAMPLE_BITS+23:0]      in_rad,
	input  logic [SAMPLE_BITS+13:0]        in_rem,
	input  logic [SAMPLE_BITS+11:0]        in_root,
	input  logic [SAMPLE_BITS+1:0]         in_sum,
	input  ptx_ph_tag_t                    in_tag,
	output logic                           out_valid,
	output logic signed [SAMPLE_BITS+19:0] out_cx,
	output logic signed [SAMPLE_BITS+19:0] out_cy,
	output logic signed [ANGLE_W-1:0]      out_z,
	output logic [2*SAMPLE_BITS+23:0]      out_rad,
	output logic [SAMPLE_BITS+13:0]        out_rem,
	output logic [SAMPLE_BITS+11:0]        out_root,
	output logic [SAMPLE_BITS+1:0]         out_sum,
	output ptx_ph_tag_t                    out_tag
);

	localparam int CW     = SAMPLE_BITS + 20;
	localparam int ROOT_W = SAMPLE_BITS + 12;
	localparam int REM_W  = ROOT_W + 2;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam bit ROTATE  = (IDX < CORDIC_STAGES) && (IDX < ATAN_LEN);
	localparam bit ROOT_ON = (IDX < ROOT_W);
	localparam logic signed [ANGLE_W-1:0] ANGLE = ptx_atan(IDX);

	logic signed [CW-1:0]      sx, sy, cx_n, cy_n;
	logic signed [ANGLE_W-1:0] z_n;
	logic [REM_W+1:0]          trial, divs;
	logic                      ge;
	logic [REM_W-1:0]          rem_n;
	logic [ROOT_W-1:0]         root_n;
	logic [RAD_W-1:0]          rad_n;

	logic                      valid_q;
	logic signed [CW-1:0]      cx_q, cy_q;
	logic signed [ANGLE_W-1:0] z_q;
	logic [RAD_W-1:0]          rad_q;
	logic [REM_W-1:0]          rem_q;
	logic [ROOT_W-1:0]         root_q;
	logic [SAMPLE_BITS+1:0]    sum_q;
	ptx_ph_tag_t               tag_q;

	// One vectoring rotation when ROTATE is set: drive y toward zero, keep the angle.
	assign sx = in_cx >>> IDX;
	assign sy = in_cy >>> IDX;

	always_comb begin
		cx_n = in_cx;
		cy_n = in_cy;
		z_n  = in_z;
		if (ROTATE) begin
			if (!in_cy[CW-1]) begin
				cx_n = in_cx + sy;
				cy_n = in_cy - sx;
				z_n  = in_z + ANGLE;
			end else begin
				cx_n = in_cx - sy;
				cy_n = in_cy + sx;
				z_n  = in_z - ANGLE;
			end
		end
	end

	// One restoring square-root digit when ROOT_ON is set: bring down two radicand bits.
	assign trial = {in_rem, in_rad[RAD_W-1 -: 2]};
	assign divs  = (REM_W+2)'({in_root, 2'b01});
	assign ge    = (trial >= divs);

	always_comb begin
		rem_n  = in_rem;
		root_n = in_root;
		rad_n  = in_rad;
		if (ROOT_ON) begin
			rem_n  = ge ? REM_W'(trial - divs) : REM_W'(trial);
			root_n = {in_root[ROOT_W-2:0], ge};
			rad_n  = in_rad << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_q   <= cx_n;
			cy_q   <= cy_n;
			z_q    <= z_n;
			rad_q  <= rad_n;
			rem_q  <= rem_n;
			root_q <= root_n;
			sum_q  <= in_sum;
			tag_q  <= in_tag;
		end
	end

	assign out_valid = valid_q;
	assign out_cx    = cx_q;
	assign out_cy    = cy_q;
	assign out_z     = z_q;
	assign out_rad   = rad_q;
	assign out_rem   = rem_q;
	assign out_root  = root_q;
	assign out_sum   = sum_q;
	assign out_tag   = tag_q;

endmodule

[sv/ptx_back.sv]
module ptx_back import ptx_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_valid,
	input  logic signed [ANGLE_W-1:0] z,
	input  logic [SAMPLE_BITS+11:0]   root,
	input  logic [SAMPLE_BITS+1:0]    sum,
	input  ptx_ph_tag_t               tag,
	output logic                      out_valid,
	output ptx_result_t               result
);

	localparam int NUM_W  = SAMPLE_BITS + 13;
	localparam int DIV_W  = NUM_W - ROUND_SHIFT + 1;
	localparam int RSH    = DIV_W + 1;
	localparam int PROD_W = 2 * DIV_W;
	localparam logic [PROD_W-1:0] RECIP = PROD_W'((2**RSH + 2) / 3);

	logic signed [ANGLE_W:0]   zb, zsh;
	logic signed [PHASE_W-1:0] ph_cordic, ph;
	logic [NUM_W-1:0]          num;
	logic [NUM_W:0]            nb;
	logic [DIV_W-1:0]          quarter;
	logic [PROD_W-1:0]         prod;

	logic                      v_f1, v_f2;
	logic signed [PHASE_W-1:0] ph_f1, ph_f2;
	logic [DIV_W-1:0]          quarter_f1;
	logic [TEXTURE_W-1:0]      tex_f2;

	// Round the Q2.30 angle to Q3.13, nearest, then clamp to half pi.
	assign zb  = (ANGLE_W+1)'(z) + ANGLE_ROUND;
	assign zsh = zb >>> ANGLE_SHIFT;

	always_comb begin
		if (zsh > HALF_PI_Q13) begin
			ph_cordic = HALF_PI_Q13;
		end else if (zsh < -HALF_PI_Q13) begin
			ph_cordic = -HALF_PI_Q13;
		end else begin
			ph_cordic = PHASE_W'(zsh);
		end
	end

	assign ph = tag.special ? tag.value : ph_cordic;

	// Texture numerator in 1/1024 units; the divide by three follows.
	assign num     = (NUM_W'(sum) << SUM_SHIFT) + NUM_W'(root);
	assign nb      = (NUM_W+1)'(num) + (NUM_W+1)'(ROUND_BIAS);
	assign quarter = DIV_W'(nb >> ROUND_SHIFT);
	assign prod    = PROD_W'(quarter_f1) * RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
		end else if (adv) begin
			v_f1 <= in_valid;
			v_f2 <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_f1      <= ph;
			quarter_f1 <= quarter;
			ph_f2      <= ph_f1;
			tex_f2     <= TEXTURE_W'(prod >> RSH);
		end
	end

	assign out_valid      = v_f2;
	assign result.phase   = ph_f2;
	assign result.texture = tex_f2;

endmodule

[sv/ptx_out.sv]
`include "assert_macros.svh"

module ptx_out import ptx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pipe_valid,
	input  ptx_result_t pipe_data,
	output logic        adv,
	output logic        in_stall,
	output logic        out_valid,
	output ptx_result_t out_data,
	input  logic        out_stall
);

	logic        out_valid_q, skid_valid_q;
	ptx_result_t out_data_q, skid_data_q;
	logic        out_take, leaving;

	// The pipeline moves unless the skid register holds an item.
	assign adv      = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign out_take = !out_valid_q || !out_stall;
	assign leaving  = pipe_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= leaving;
			end
		end else if (leaving) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			out_data_q <= skid_valid_q ? skid_data_q : pipe_data;
		end
		if (!out_take && leaving) begin
			skid_data_q <= pipe_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`PTX_ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q, "skid full with output empty")
	`PTX_ASSERT_NEXT(a_skid_catches, clk, arst_n, out_valid_q && out_stall && !skid_valid_q && pipe_valid, skid_valid_q, "stalled result not caught by skid")
	`PTX_ASSERT_NEXT(a_out_drains, clk, arst_n, out_valid_q && !out_stall && !skid_valid_q && !pipe_valid, !out_valid_q, "output kept a delivered result")

endmodule

[sv/three_step_phase_texture_top.sv]
// Three-step phase-shifting pixel unit.
// The pixel channel (pixel_valid, pixel_stall, pixel) carries one triple of co-located
// intensities per transfer; only the low SAMPLE_BITS bits of each sample are used.
// The result channel (result_valid, result_stall, result) returns one transfer per pixel,
// in order: the wrapped phase in signed Q3.13 and the texture in quarter units.
// A pixel transfer reaches its result on the port through three front stages, one row
// of cells that each do at most one CORDIC rotation and one square-root digit, two
// back stages for rounding and the divide by three, and the output register.
// The row length is set by the square-root digit count or the CORDIC depth, whichever
// is larger. One pixel is accepted every cycle while the result side keeps up.
// The block keeps no state between pixels; reset only empties the pipeline.
// When the receiver stalls, one more result is caught in a skid register and then
// pixel_stall rises; the whole pipeline holds until the skid register drains.
module three_step_phase_texture_top import ptx_pkg::*; #(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  ptx_pixel_t  pixel,
	output logic        result_valid,
	input  logic        result_stall,
	output ptx_result_t result
);

	localparam int CW     = SAMPLE_BITS + 20;
	localparam int ROOT_W = SAMPLE_BITS + 12;
	localparam int REM_W  = ROOT_W + 2;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int SUM_W  = SAMPLE_BITS + 2;
	localparam int CELLS  = (CORDIC_STAGES > ROOT_W) ? CORDIC_STAGES : ROOT_W;

	// Pipeline-wide advance from the output side.
	logic adv;

	// Taps between neighboring cells; tap 0 is fed by the front stages.
	logic                      ch_valid [CELLS+1];
	logic signed [CW-1:0]      ch_cx    [CELLS+1];
	logic signed [CW-1:0]      ch_cy    [CELLS+1];
	logic signed [ANGLE_W-1:0] ch_z     [CELLS+1];
	logic [RAD_W-1:0]          ch_rad   [CELLS+1];
	logic [REM_W-1:0]          ch_rem   [CELLS+1];
	logic [ROOT_W-1:0]         ch_root  [CELLS+1];
	logic [SUM_W-1:0]          ch_sum   [CELLS+1];
	ptx_ph_tag_t               ch_tag   [CELLS+1];

	logic        back_valid;
	ptx_result_t back_data;

	ptx_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (pixel_valid),
		.pix      (pixel),
		.out_valid(ch_valid[0]),
		.cx       (ch_cx[0]),
		.cy       (ch_cy[0]),
		.rad      (ch_rad[0]),
		.sum      (ch_sum[0]),
		.tag      (ch_tag[0])
	);

	// The angle, remainder and root all start from zero.
	assign ch_z[0]    = '0;
	assign ch_rem[0]  = '0;
	assign ch_root[0] = '0;

	for (genvar i = 0; i < CELLS; i++) begin : g_row
		ptx_cell #(
			.IDX          (i),
			.SAMPLE_BITS  (SAMPLE_BITS),
			.CORDIC_STAGES(CORDIC_STAGES)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (ch_valid[i]),
			.in_cx    (ch_cx[i]),
			.in_cy    (ch_cy[i]),
			.in_z     (ch_z[i]),
			.in_rad   (ch_rad[i]),
			.in_rem   (ch_rem[i]),
			.in_root  (ch_root[i]),
			.in_sum   (ch_sum[i]),
			.in_tag   (ch_tag[i]),
			.out_valid(ch_valid[i+1]),
			.out_cx   (ch_cx[i+1]),
			.out_cy   (ch_cy[i+1]),
			.out_z    (ch_z[i+1]),
			.out_rad  (ch_rad[i+1]),
			.out_rem  (ch_rem[i+1]),
			.out_root (ch_root[i+1]),
			.out_sum  (ch_sum[i+1]),
			.out_tag  (ch_tag[i+1])
		);
	end

	ptx_back #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (ch_valid[CELLS]),
		.z        (ch_z[CELLS]),
		.root     (ch_root[CELLS]),
		.sum      (ch_sum[CELLS]),
		.tag      (ch_tag[CELLS]),
		.out_valid(back_valid),
		.result   (back_data)
	);

	// Output register with a skid stage, so the pixel side never waits on
	// the receiver in the same cycle.
	ptx_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.pipe_valid(back_valid),
		.pipe_data (back_data),
		.adv       (adv),
		.in_stall  (pixel_stall),
		.out_valid (result_valid),
		.out_data  (result),
		.out_stall (result_stall)
	);

endmodule
